[src/sensor_sample_fifo_registers_macros.svh]
// ----------------------------------------------------------------------------
// sensor sample fifo registers assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef SENSOR_SAMPLE_FIFO_REGISTERS_MACROS_SVH
`define SENSOR_SAMPLE_FIFO_REGISTERS_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define SFR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define SFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[src/sfr_pkg.sv]
// ----------------------------------------------------------------------------
// sfr_pkg
// types and fixed codes shared by the sensor sample fifo register block
// ----------------------------------------------------------------------------
package sfr_pkg;

    // item kinds
    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_SAMPLE = 2'd2;

    // register map
    localparam logic [7:0] ADDR_IRQ_STATUS = 8'h00;
    localparam logic [7:0] ADDR_IRQ_ENABLE = 8'h01;
    localparam logic [7:0] ADDR_WR_PTR     = 8'h02;
    localparam logic [7:0] ADDR_OVF_COUNT  = 8'h03;
    localparam logic [7:0] ADDR_RD_PTR     = 8'h04;
    localparam logic [7:0] ADDR_FIFO_DATA  = 8'h05;
    localparam logic [7:0] ADDR_MODE       = 8'h06;
    localparam logic [7:0] ADDR_SAMPLE_CFG = 8'h07;
    localparam logic [7:0] ADDR_LED_CFG    = 8'h09;
    localparam logic [7:0] ADDR_REV_ID     = 8'hFE;
    localparam logic [7:0] ADDR_PART_ID    = 8'hFF;

    localparam logic [7:0] PART_ID_VALUE  = 8'h11;
    localparam int unsigned MODE_RESET_BIT = 6;
    localparam logic [3:0] OVF_MAX        = 4'hF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  reg_addr;
        logic [7:0]  write_data;
        logic [15:0] ir_value;
        logic [15:0] red_value;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic [3:0] available_count;
    } t_result;

endpackage

[src/sensor_sample_fifo_registers.sv]
// ----------------------------------------------------------------------------
// sensor_sample_fifo_registers
// register side of an optical pulse sensor with a ring of converter samples
// ----------------------------------------------------------------------------
// usage
//   command channel: a word (kind, reg_addr, write_data, ir_value, red_value)
//   is taken at a clock edge where start is high and busy is low
//   kinds: bus register write, bus register read, new converter sample;
//   the unused fourth kind is taken and dropped with no result
//   result channel: o_done is high for one cycle with o_read_data and
//   o_available_count; the receiver cannot hold results off
//   timing: the word is registered at the accepting edge, and o_done is
//   registered from the execute cycle that follows
//   pacing: no new word is taken while one executes; the ring memory read is issued
//   at the accepting edge and the read-modify-write of the pointers and
//   ring entry happens in the next cycle, with busy high during it
//   config: i_cfg_we writes i_cfg_wdata into the revision id register;
//   use it only while no word is in flight, the block itself does not enforce this
//   reset: synchronous active low i_rst_n clears pointers, counts and
//   register bytes; ring contents stay undefined until written
// ----------------------------------------------------------------------------
`include "sensor_sample_fifo_registers_macros.svh"

module sensor_sample_fifo_registers #(
    parameter int RING_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_reg_addr,
    input  logic [7:0]  i_write_data,
    input  logic [15:0] i_ir_value,
    input  logic [15:0] i_red_value,
    // result channel
    output logic        o_done,
    output logic [7:0]  o_read_data,
    output logic [3:0]  o_available_count,
    // revision id register
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata
);

    localparam int IW = $clog2(RING_DEPTH);

    logic             accept;
    logic             r_busy;
    sfr_pkg::t_item   r_item;
    logic [7:0]       r_revision_id;
    logic             r_done;
    logic [7:0]       r_read_data;
    logic [3:0]       r_avail;

    sfr_pkg::t_result exec_result;
    logic [IW-1:0]    rd_index;
    logic             ring_wr_en;
    logic [IW-1:0]    ring_wr_addr;
    logic [31:0]      ring_wr_data;
    logic [31:0]      ring_rd_data;

    // a word is taken only when nothing is executing
    assign accept = start && !r_busy;
    assign busy   = r_busy;

    // capture the word; it executes in the following cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= '{kind: i_kind, reg_addr: i_reg_addr, write_data: i_write_data,
                        ir_value: i_ir_value, red_value: i_red_value};
        end
    end

    // revision id survives the mode reset bit; only i_rst_n and the config port change it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_revision_id <= '0;
        end else if (i_cfg_we) begin
            r_revision_id <= i_cfg_wdata;
        end
    end

    // ring read is issued at the accept edge so data is ready during execute
    sfr_ring_ram #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (ring_wr_en),
        .i_wr_addr (ring_wr_addr),
        .i_wr_data (ring_wr_data),
        .i_rd_en   (accept),
        .i_rd_addr (rd_index),
        .o_rd_data (ring_rd_data)
    );

    sfr_ctrl #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_exec         (r_busy),
        .i_item         (r_item),
        .i_revision_id  (r_revision_id),
        .i_ring_data    (ring_rd_data),
        .o_rd_index     (rd_index),
        .o_ring_wr_en   (ring_wr_en),
        .o_ring_wr_addr (ring_wr_addr),
        .o_ring_wr_data (ring_wr_data),
        .o_result       (exec_result)
    );

    // result register; the unused kind produces no strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_item.kind inside {sfr_pkg::KIND_WRITE,
                                                     sfr_pkg::KIND_READ,
                                                     sfr_pkg::KIND_SAMPLE});
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_read_data <= exec_result.read_data;
            r_avail     <= exec_result.available_count;
        end
    end

    assign o_done            = r_done;
    assign o_read_data       = r_read_data;
    assign o_available_count = r_avail;

    // an accepted word executes in the cycle after, and execute never repeats back to back
    `SFR_ASSERT_NEXT(a_accept_execs, accept, r_busy, "accepted word did not execute")
    `SFR_ASSERT_NEXT(a_exec_single, r_busy, !r_busy, "execute stage held for two cycles")
    // a strobe only follows an execute cycle
    `SFR_ASSERT_SAME(a_done_after_exec, o_done, $past(r_busy), "result without execute")
    // ring writes only come from a sample word in execute
    `SFR_ASSERT_SAME(a_ring_wr_sample, ring_wr_en,
                     r_busy && r_item.kind == sfr_pkg::KIND_SAMPLE,
                     "ring write outside a sample execute")

endmodule

[src/sfr_ring_ram.sv]
// ----------------------------------------------------------------------------
// sfr_ring_ram
// sample ring storage, one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module sfr_ring_ram #(
    parameter int RING_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [$clog2(RING_DEPTH)-1:0] i_wr_addr,
    input  logic [31:0]                   i_wr_data,
    input  logic                          i_rd_en,
    input  logic [$clog2(RING_DEPTH)-1:0] i_rd_addr,
    output logic [31:0]                   o_rd_data
);

    logic [31:0] r_mem [RING_DEPTH];
    logic [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/sfr_ctrl.sv]
// ----------------------------------------------------------------------------
// sfr_ctrl
// register file and ring pointers, updated once per executed word
// ----------------------------------------------------------------------------
module sfr_ctrl #(
    parameter int RING_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_exec,
    input  sfr_pkg::t_item                i_item,
    input  logic [7:0]                    i_revision_id,
    input  logic [31:0]                   i_ring_data,
    output logic [$clog2(RING_DEPTH)-1:0] o_rd_index,
    output logic                          o_ring_wr_en,
    output logic [$clog2(RING_DEPTH)-1:0] o_ring_wr_addr,
    output logic [31:0]                   o_ring_wr_data,
    output sfr_pkg::t_result              o_result
);

    localparam int IW = $clog2(RING_DEPTH);
    localparam int CW = (IW > 4) ? IW : 4;
    localparam int unsigned RECIP = 65536 / RING_DEPTH;
    localparam logic [IW-1:0] LAST_INDEX = IW'(RING_DEPTH - 1);

    logic [IW-1:0] r_write_index, n_write_index;
    logic [IW-1:0] r_read_index,  n_read_index;
    logic [3:0]    r_ovf_count,   n_ovf_count;
    logic [1:0]    r_byte_pos,    n_byte_pos;
    logic [7:0]    r_mode,        n_mode;
    logic [7:0]    r_sample_cfg,  n_sample_cfg;
    logic [7:0]    r_led_cfg,     n_led_cfg;
    logic [7:0]    r_irq_enable,  n_irq_enable;

    logic [IW-1:0] held_now;
    logic [IW-1:0] held_next;
    logic [CW-1:0] held_ext;
    logic [IW-1:0] data_mod;
    logic [24:0]   recip_prod;
    logic [15:0]   quot_times;
    logic [7:0]    rem_raw;
    logic [7:0]    rd_byte;
    logic [7:0]    data_byte;

    // ring occupancy, modulo the depth
    function automatic logic [IW-1:0] occupancy(input logic [IW-1:0] wi,
                                                input logic [IW-1:0] ri);
        logic [IW:0] sum;
        sum = {1'b0, wi} + (IW+1)'(RING_DEPTH) - {1'b0, ri};
        if (wi >= ri) begin
            return wi - ri;
        end else begin
            return sum[IW-1:0];
        end
    endfunction

    function automatic logic [IW-1:0] next_index(input logic [IW-1:0] idx);
        if (idx == LAST_INDEX) begin
            return '0;
        end else begin
            return idx + 1'b1;
        end
    endfunction

    // write data modulo depth: reciprocal multiply, one correction step
    always_comb begin
        recip_prod = 25'(i_item.write_data) * 25'(RECIP);
        quot_times = 16'(recip_prod[23:16]) * 16'(RING_DEPTH);
        rem_raw    = i_item.write_data - quot_times[7:0];
        if (rem_raw >= 8'(RING_DEPTH)) begin
            data_mod = IW'(rem_raw - 8'(RING_DEPTH));
        end else begin
            data_mod = IW'(rem_raw);
        end
    end

    assign held_now = occupancy(r_write_index, r_read_index);

    always_comb begin
        case (r_byte_pos)
            2'd0:    data_byte = i_ring_data[31:24];
            2'd1:    data_byte = i_ring_data[23:16];
            2'd2:    data_byte = i_ring_data[15:8];
            default: data_byte = i_ring_data[7:0];
        endcase
    end

    always_comb begin
        n_write_index = r_write_index;
        n_read_index  = r_read_index;
        n_ovf_count   = r_ovf_count;
        n_byte_pos    = r_byte_pos;
        n_mode        = r_mode;
        n_sample_cfg  = r_sample_cfg;
        n_led_cfg     = r_led_cfg;
        n_irq_enable  = r_irq_enable;
        rd_byte       = 8'h00;
        o_ring_wr_en  = 1'b0;
        if (i_exec) begin
            case (i_item.kind)
                sfr_pkg::KIND_WRITE: begin
                    case (i_item.reg_addr)
                        sfr_pkg::ADDR_IRQ_ENABLE: n_irq_enable = i_item.write_data;
                        sfr_pkg::ADDR_WR_PTR: begin
                            n_write_index = data_mod;
                            n_byte_pos    = 2'd0;
                        end
                        sfr_pkg::ADDR_OVF_COUNT: n_ovf_count = i_item.write_data[3:0];
                        sfr_pkg::ADDR_RD_PTR: begin
                            n_read_index = data_mod;
                            n_byte_pos   = 2'd0;
                        end
                        sfr_pkg::ADDR_MODE: begin
                            if (i_item.write_data[sfr_pkg::MODE_RESET_BIT]) begin
                                n_write_index = '0;
                                n_read_index  = '0;
                                n_ovf_count   = '0;
                                n_byte_pos    = '0;
                                n_mode        = '0;
                                n_sample_cfg  = '0;
                                n_led_cfg     = '0;
                                n_irq_enable  = '0;
                            end else begin
                                n_mode = i_item.write_data;
                            end
                        end
                        sfr_pkg::ADDR_SAMPLE_CFG: n_sample_cfg = i_item.write_data;
                        sfr_pkg::ADDR_LED_CFG:    n_led_cfg    = i_item.write_data;
                        default: ;
                    endcase
                end
                sfr_pkg::KIND_READ: begin
                    case (i_item.reg_addr)
                        sfr_pkg::ADDR_IRQ_STATUS: rd_byte = 8'h00;
                        sfr_pkg::ADDR_IRQ_ENABLE: rd_byte = r_irq_enable;
                        sfr_pkg::ADDR_WR_PTR:     rd_byte = 8'(r_write_index);
                        sfr_pkg::ADDR_OVF_COUNT:  rd_byte = 8'(r_ovf_count);
                        sfr_pkg::ADDR_RD_PTR:     rd_byte = 8'(r_read_index);
                        sfr_pkg::ADDR_FIFO_DATA: begin
                            if (held_now != '0) begin
                                rd_byte    = data_byte;
                                n_byte_pos = r_byte_pos + 2'd1;
                                if (r_byte_pos == 2'd3) begin
                                    n_read_index = next_index(r_read_index);
                                end
                            end
                        end
                        sfr_pkg::ADDR_MODE:       rd_byte = r_mode;
                        sfr_pkg::ADDR_SAMPLE_CFG: rd_byte = r_sample_cfg;
                        sfr_pkg::ADDR_LED_CFG:    rd_byte = r_led_cfg;
                        sfr_pkg::ADDR_REV_ID:     rd_byte = i_revision_id;
                        sfr_pkg::ADDR_PART_ID:    rd_byte = sfr_pkg::PART_ID_VALUE;
                        default:                  rd_byte = 8'h00;
                    endcase
                end
                sfr_pkg::KIND_SAMPLE: begin
                    if (held_now >= LAST_INDEX) begin
                        if (r_ovf_count != sfr_pkg::OVF_MAX) begin
                            n_ovf_count = r_ovf_count + 4'd1;
                        end
                    end else begin
                        o_ring_wr_en  = 1'b1;
                        n_write_index = next_index(r_write_index);
                    end
                end
                default: ;
            endcase
        end
    end

    assign held_next = occupancy(n_write_index, n_read_index);
    assign held_ext  = CW'(held_next);

    assign o_result.read_data       = rd_byte;
    assign o_result.available_count = held_ext[3:0];
    assign o_rd_index               = r_read_index;
    assign o_ring_wr_addr           = r_write_index;
    assign o_ring_wr_data           = {i_item.ir_value, i_item.red_value};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_index <= '0;
            r_read_index  <= '0;
            r_ovf_count   <= '0;
            r_byte_pos    <= '0;
            r_mode        <= '0;
            r_sample_cfg  <= '0;
            r_led_cfg     <= '0;
            r_irq_enable  <= '0;
        end else begin
            r_write_index <= n_write_index;
            r_read_index  <= n_read_index;
            r_ovf_count   <= n_ovf_count;
            r_byte_pos    <= n_byte_pos;
            r_mode        <= n_mode;
            r_sample_cfg  <= n_sample_cfg;
            r_led_cfg     <= n_led_cfg;
            r_irq_enable  <= n_irq_enable;
        end
    end

endmodule

[test/tb_sensor_sample_fifo_registers.sv]
// ----------------------------------------------------------------------------
// tb_sensor_sample_fifo_registers
// self-checking bench: a directed table of register, ring and id accesses,
// then paced random traffic over several revision id settings, every result
// word compared against a cycle-free predictor of the register file and ring
// ----------------------------------------------------------------------------
module tb_sensor_sample_fifo_registers;

    timeunit 1ns;
    timeprecision 1ps;

    // ring size of the instance, pointers are 4 bits wide
    localparam int DEPTH = 16;

    // codes the package does not name
    localparam logic [1:0] KIND_UNUSED   = 2'd3;
    localparam logic [7:0] ADDR_UNMAPPED = 8'h08;

    // stimulus sizes and waiting limits
    localparam int RANDOM_WORDS  = 950;
    localparam int PHASES        = 5;
    localparam int DRAIN_LIMIT   = 200;
    localparam int SETTLE_CYCLES = 4;
    localparam int SHOWN_ERRORS  = 10;

    // one directed row: the word, and the reply typed in where it is obvious
    typedef struct {
        sfr_pkg::t_item   word;
        bit               typed;
        sfr_pkg::t_result want;
    } t_stim_row;

    // clock, reset and all block inputs start at known values
    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        start        = 1'b0;
    logic [1:0]  i_kind       = '0;
    logic [7:0]  i_reg_addr   = '0;
    logic [7:0]  i_write_data = '0;
    logic [15:0] i_ir_value   = '0;
    logic [15:0] i_red_value  = '0;
    logic        i_cfg_we     = 1'b0;
    logic [7:0]  i_cfg_wdata  = '0;

    logic        busy;
    logic        o_done;
    logic [7:0]  o_read_data;
    logic [3:0]  o_available_count;

    // predicted device state, reset values
    logic [31:0]      ring_mem [DEPTH];
    logic [DEPTH-1:0] ring_written = '0;
    logic [3:0]       wr_ptr       = '0;
    logic [3:0]       rd_ptr       = '0;
    logic [3:0]       ovf_cnt      = '0;
    logic [1:0]       byte_sel     = '0;
    logic [7:0]       mode_reg     = '0;
    logic [7:0]       sample_cfg_reg = '0;
    logic [7:0]       led_reg      = '0;
    logic [7:0]       irq_en_reg   = '0;
    logic [7:0]       revision_reg = '0;

    // replies still owed by the block, oldest first
    sfr_pkg::t_result pending_replies [$];

    // bookkeeping
    int err_count       = 0;
    int words_sent      = 0;
    int replies_checked = 0;
    int ring_bytes_read = 0;
    int samples_dropped = 0;
    int device_clears   = 0;
    int burst_left      = 0;

    sensor_sample_fifo_registers #(
        .RING_DEPTH(DEPTH)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_kind           (i_kind),
        .i_reg_addr       (i_reg_addr),
        .i_write_data     (i_write_data),
        .i_ir_value       (i_ir_value),
        .i_red_value      (i_red_value),
        .o_done           (o_done),
        .o_read_data      (o_read_data),
        .o_available_count(o_available_count),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // samples held, the pointer difference wraps on its own at 4 bits
    function automatic logic [3:0] ring_level();
        return wr_ptr - rd_ptr;
    endfunction

    function automatic sfr_pkg::t_item mk_word(logic [1:0] kind, logic [7:0] addr,
                                               logic [7:0] data, logic [15:0] ir,
                                               logic [15:0] red);
        sfr_pkg::t_item w;
        w.kind       = kind;
        w.reg_addr   = addr;
        w.write_data = data;
        w.ir_value   = ir;
        w.red_value  = red;
        return w;
    endfunction

    function automatic t_stim_row stim_row(logic [1:0] kind, logic [7:0] addr,
                                           logic [7:0] data, logic [15:0] ir,
                                           logic [15:0] red, bit typed,
                                           logic [7:0] rd, logic [3:0] cnt);
        t_stim_row r;
        r.word                 = mk_word(kind, addr, data, ir, red);
        r.typed                = typed;
        r.want.read_data       = rd;
        r.want.available_count = cnt;
        return r;
    endfunction

    // converter values, leaning on the rails now and then
    function automatic logic [15:0] sample_value();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // predictor: applies one accepted word to the state and forms its reply
    task automatic sensor_access(input sfr_pkg::t_item w, output bit has_reply,
                                 output sfr_pkg::t_result reply);
        logic [31:0] entry;
        has_reply       = 1'b1;
        reply.read_data = 8'h00;
        case (w.kind)
            sfr_pkg::KIND_WRITE: begin
                case (w.reg_addr)
                    sfr_pkg::ADDR_IRQ_ENABLE: irq_en_reg = w.write_data;
                    sfr_pkg::ADDR_WR_PTR: begin
                        wr_ptr   = w.write_data[3:0];
                        byte_sel = '0;
                    end
                    sfr_pkg::ADDR_OVF_COUNT: ovf_cnt = w.write_data[3:0];
                    sfr_pkg::ADDR_RD_PTR: begin
                        rd_ptr   = w.write_data[3:0];
                        byte_sel = '0;
                    end
                    sfr_pkg::ADDR_MODE: begin
                        if (w.write_data[sfr_pkg::MODE_RESET_BIT]) begin
                            // soft reset: everything but the revision id
                            ring_written   = '0;
                            wr_ptr         = '0;
                            rd_ptr         = '0;
                            ovf_cnt        = '0;
                            byte_sel       = '0;
                            mode_reg       = '0;
                            sample_cfg_reg = '0;
                            led_reg        = '0;
                            irq_en_reg     = '0;
                            device_clears++;
                        end else begin
                            mode_reg = w.write_data;
                        end
                    end
                    sfr_pkg::ADDR_SAMPLE_CFG: sample_cfg_reg = w.write_data;
                    sfr_pkg::ADDR_LED_CFG:    led_reg = w.write_data;
                    default: ;
                endcase
            end
            sfr_pkg::KIND_READ: begin
                case (w.reg_addr)
                    sfr_pkg::ADDR_IRQ_ENABLE: reply.read_data = irq_en_reg;
                    sfr_pkg::ADDR_WR_PTR:     reply.read_data = {4'h0, wr_ptr};
                    sfr_pkg::ADDR_OVF_COUNT:  reply.read_data = {4'h0, ovf_cnt};
                    sfr_pkg::ADDR_RD_PTR:     reply.read_data = {4'h0, rd_ptr};
                    sfr_pkg::ADDR_FIFO_DATA: begin
                        // empty ring reads zero and leaves the byte order alone
                        if (ring_level() != 4'd0) begin
                            entry = ring_mem[rd_ptr];
                            case (byte_sel)
                                2'd0:    reply.read_data = entry[31:24];
                                2'd1:    reply.read_data = entry[23:16];
                                2'd2:    reply.read_data = entry[15:8];
                                default: reply.read_data = entry[7:0];
                            endcase
                            byte_sel = byte_sel + 2'd1;
                            if (byte_sel == 2'd0)
                                rd_ptr = rd_ptr + 4'd1;
                            ring_bytes_read++;
                        end
                    end
                    sfr_pkg::ADDR_MODE:       reply.read_data = mode_reg;
                    sfr_pkg::ADDR_SAMPLE_CFG: reply.read_data = sample_cfg_reg;
                    sfr_pkg::ADDR_LED_CFG:    reply.read_data = led_reg;
                    sfr_pkg::ADDR_REV_ID:     reply.read_data = revision_reg;
                    sfr_pkg::ADDR_PART_ID:    reply.read_data = sfr_pkg::PART_ID_VALUE;
                    default: ;
                endcase
            end
            sfr_pkg::KIND_SAMPLE: begin
                // one slot stays free, a sample into a full ring is counted and lost
                if (ring_level() == 4'(DEPTH - 1)) begin
                    if (ovf_cnt != sfr_pkg::OVF_MAX)
                        ovf_cnt = ovf_cnt + 4'd1;
                    samples_dropped++;
                end else begin
                    ring_mem[wr_ptr]     = {w.ir_value, w.red_value};
                    ring_written[wr_ptr] = 1'b1;
                    wr_ptr               = wr_ptr + 4'd1;
                end
            end
            default: has_reply = 1'b0;
        endcase
        reply.available_count = ring_level();
    endtask

    task automatic note_error(input string msg);
        err_count++;
        if (err_count <= SHOWN_ERRORS)
            $display("tb: error at %0t: %s", $realtime, msg);
    endtask

    // lower start and wait for every owed reply, then let a dropped word settle
    task automatic drain_replies();
        int waited;
        waited = 0;
        start <= 1'b0;
        while (pending_replies.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_replies.size() != 0) begin
            note_error($sformatf("%0d replies never arrived", pending_replies.size()));
            pending_replies.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // sender pacing: bursts of back-to-back words, random gaps between them,
    // and now and then a full stop until the block has answered everything
    task automatic pace_sender();
        if (burst_left == 0) begin
            if ($urandom_range(0, 49) == 0) begin
                drain_replies();
            end else if ($urandom_range(0, 3) != 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
    endtask

    // present one word, hold it until accepted, then predict its reply
    task automatic send_word(input sfr_pkg::t_item w, input bit typed,
                             input sfr_pkg::t_result want);
        bit               has_reply;
        sfr_pkg::t_result reply;
        pace_sender();
        // never read a ring slot that holds nothing written since the last clear;
        // empty the ring by a read pointer write instead
        if (w.kind == sfr_pkg::KIND_READ && w.reg_addr == sfr_pkg::ADDR_FIFO_DATA
                && ring_level() != 4'd0 && !ring_written[rd_ptr]) begin
            w.kind       = sfr_pkg::KIND_WRITE;
            w.reg_addr   = sfr_pkg::ADDR_RD_PTR;
            w.write_data = {4'($urandom), wr_ptr};
            typed        = 1'b0;
        end
        start        <= 1'b1;
        i_kind       <= w.kind;
        i_reg_addr   <= w.reg_addr;
        i_write_data <= w.write_data;
        i_ir_value   <= w.ir_value;
        i_red_value  <= w.red_value;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        sensor_access(w, has_reply, reply);
        if (has_reply)
            pending_replies.push_back(typed ? want : reply);
        if (w.kind != KIND_UNUSED)
            words_sent++;
    endtask

    // reply checker, sampled mid-cycle so it never races the driving edge
    always @(negedge i_clk) begin : reply_check
        sfr_pkg::t_result want;
        if (i_rst_n && o_done !== 1'b0) begin
            if (pending_replies.size() == 0) begin
                note_error($sformatf("reply with none owed: data %h count %0d",
                                     o_read_data, o_available_count));
            end else begin
                want = pending_replies.pop_front();
                replies_checked++;
                if (o_read_data !== want.read_data)
                    note_error($sformatf("read_data: expected %h got %h",
                                         want.read_data, o_read_data));
                if (o_available_count !== want.available_count)
                    note_error($sformatf("available_count: expected %0d got %0d",
                                         want.available_count, o_available_count));
            end
        end
    end

    initial begin : stimulus
        t_stim_row      rows [$];
        sfr_pkg::t_item w;
        logic [7:0]     addr;
        logic [7:0]     data;
        logic [7:0]     rev;
        int             n;
        int             target;

        // hold reset for a while, then release it
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table: reset values, ids, ignored accesses, byte order of a
        // ring read at the rails, overflow count masking, soft reset
        rows.push_back(stim_row(sfr_pkg::KIND_READ, sfr_pkg::ADDR_PART_ID, 8'h00, 16'h0, 16'h0,
                                1'b1, 8'h11, 4'd0));
        rows.push_back(stim_row(sfr_pkg::KIND_READ, sfr_pkg::ADDR_REV_ID, 8'h00, 16'h0, 16'h0,
                                1'b1, 8'h00, 4'd0));
        rows.push_back(stim_row(sfr_pkg::KIND_READ, sfr_pkg::ADDR_FIFO_DATA, 8'h00, 16'h0, 16'h0,
                                1'b1, 8'h00, 4'd0));
        rows.push_back(stim_row(sfr_pkg::KIND_READ, sfr_pkg::ADDR_IRQ_STATUS, 8'h00, 16'h0, 16'h0,
                                1'b1, 8'h00, 4'd0));
        rows.push_back(stim_row(sfr_pkg::KIND_WRITE, sfr_pkg::ADDR_IRQ_STATUS, 8'hFF, 16'h0,
                                16'h0, 1'b1, 8'h00, 4'd0));
        rows.push_back(stim_row(sfr_pkg::KIND_READ, ADDR_UNMAPPED, 8'h00, 16'h0, 16'h0,
                                1'b1, 8'h00, 4'd0));
        rows.push_back(stim_row(sfr_pkg::KIND_WRITE, ADDR_UNMAPPED, 8'hFF, 16'h0, 16'h0,
                                1'b0, 8'h00, 4'd0));
        rows.push_back(stim_row(sfr_pkg::KIND_WRITE, sfr_pkg::ADDR_IRQ_ENABLE, 8'hFF, 16'h0,
                                16'h0, 1'b0, 8'h00, 4'd0));
        rows.push_back(stim_row(sfr_pkg::KIND_READ, sfr_pkg::ADDR_IRQ_ENABLE, 8'h00, 16'h0, 16'h0,
                                1'b1, 8'hFF, 4'd0));
        rows.push_back(stim_row(sfr_pkg::KIND_WRITE, sfr_pkg::ADDR_MODE, 8'hBF, 16'h0, 16'h0,
                                1'b0, 8'h00, 4'd0));
        rows.push_back(stim_row(sfr_pkg::KIND_READ, sfr_pkg::ADDR_MODE, 8'h00, 16'h0, 16'h0,
                                1'b1, 8'hBF, 4'd0));
        rows.push_back(stim_row(sfr_pkg::KIND_WRITE, sfr_pkg::ADDR_SAMPLE_CFG, 8'hA5, 16'h0,
                                16'h0, 1'b0, 8'h00, 4'd0));
        rows.push_back(stim_row(sfr_pkg::KIND_WRITE, sfr_pkg::ADDR_LED_CFG, 8'h5A, 16'h0, 16'h0,
                                1'b0, 8'h00, 4'd0));
        rows.push_back(stim_row(sfr_pkg::KIND_SAMPLE, 8'h00, 8'h00, 16'hFFFF, 16'h0000,
                                1'b1, 8'h00, 4'd1));
        rows.push_back(stim_row(sfr_pkg::KIND_SAMPLE, 8'hFF, 8'hFF, 16'h0000, 16'hFFFF,
                                1'b1, 8'h00, 4'd2));
        rows.push_back(stim_row(sfr_pkg::KIND_READ, sfr_pkg::ADDR_FIFO_DATA, 8'h00, 16'h0, 16'h0,
                                1'b1, 8'hFF, 4'd2));
        rows.push_back(stim_row(sfr_pkg::KIND_READ, sfr_pkg::ADDR_FIFO_DATA, 8'h00, 16'h0, 16'h0,
                                1'b1, 8'hFF, 4'd2));
        rows.push_back(stim_row(sfr_pkg::KIND_READ, sfr_pkg::ADDR_FIFO_DATA, 8'h00, 16'h0, 16'h0,
                                1'b1, 8'h00, 4'd2));
        rows.push_back(stim_row(sfr_pkg::KIND_READ, sfr_pkg::ADDR_FIFO_DATA, 8'h00, 16'h0, 16'h0,
                                1'b1, 8'h00, 4'd1));
        rows.push_back(stim_row(sfr_pkg::KIND_WRITE, sfr_pkg::ADDR_REV_ID, 8'hFF, 16'h0, 16'h0,
                                1'b0, 8'h00, 4'd0));
        rows.push_back(stim_row(sfr_pkg::KIND_WRITE, sfr_pkg::ADDR_OVF_COUNT, 8'hFF, 16'h0,
                                16'h0, 1'b0, 8'h00, 4'd0));
        rows.push_back(stim_row(sfr_pkg::KIND_READ, sfr_pkg::ADDR_OVF_COUNT, 8'h00, 16'h0, 16'h0,
                                1'b1, 8'h0F, 4'd1));
        rows.push_back(stim_row(sfr_pkg::KIND_WRITE, sfr_pkg::ADDR_WR_PTR, 8'hF2, 16'h0, 16'h0,
                                1'b0, 8'h00, 4'd0));
        rows.push_back(stim_row(KIND_UNUSED, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF,
                                1'b0, 8'h00, 4'd0));
        rows.push_back(stim_row(sfr_pkg::KIND_WRITE, sfr_pkg::ADDR_MODE, 8'h40, 16'h0, 16'h0,
                                1'b1, 8'h00, 4'd0));

        foreach (rows[i])
            send_word(rows[i].word, rows[i].typed, rows[i].want);

        // random phases, the revision id rewritten between them while idle
        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                drain_replies();
                case (p)
                    1:       rev = 8'hFF;
                    2:       rev = 8'h00;
                    default: rev = 8'($urandom);
                endcase
                i_cfg_we    <= 1'b1;
                i_cfg_wdata <= rev;
                @(posedge i_clk);
                i_cfg_we     <= 1'b0;
                revision_reg = rev;
                send_word(mk_word(sfr_pkg::KIND_READ, sfr_pkg::ADDR_REV_ID, 8'($urandom),
                                  16'($urandom), 16'($urandom)), 1'b0, '0);
            end
            target = words_sent + RANDOM_WORDS / PHASES;
            while (words_sent < target) begin
                n = $urandom_range(0, 99);
                if (n < 25) begin
                    // sample burst, long enough at times to fill the ring
                    repeat ($urandom_range(1, 20))
                        send_word(mk_word(sfr_pkg::KIND_SAMPLE, 8'($urandom), 8'($urandom),
                                          sample_value(), sample_value()), 1'b0, '0);
                end else if (n < 50) begin
                    // whole samples read back, sometimes stopping mid-sample
                    repeat (4 * $urandom_range(1, 4) - $urandom_range(0, 3))
                        send_word(mk_word(sfr_pkg::KIND_READ, sfr_pkg::ADDR_FIFO_DATA,
                                          8'($urandom), 16'($urandom), 16'($urandom)),
                                  1'b0, '0);
                end else if (n < 65) begin
                    // plain register write then read back
                    case ($urandom_range(0, 4))
                        0:       addr = sfr_pkg::ADDR_IRQ_ENABLE;
                        1:       addr = sfr_pkg::ADDR_OVF_COUNT;
                        2:       addr = sfr_pkg::ADDR_MODE;
                        3:       addr = sfr_pkg::ADDR_SAMPLE_CFG;
                        default: addr = sfr_pkg::ADDR_LED_CFG;
                    endcase
                    data = 8'($urandom);
                    if (addr == sfr_pkg::ADDR_MODE)
                        data[sfr_pkg::MODE_RESET_BIT] = 1'b0;
                    send_word(mk_word(sfr_pkg::KIND_WRITE, addr, data, 16'($urandom),
                                      16'($urandom)), 1'b0, '0);
                    send_word(mk_word(sfr_pkg::KIND_READ, addr, 8'($urandom), 16'($urandom),
                                      16'($urandom)), 1'b0, '0);
                end else if (n < 73) begin
                    // pointer moved by the bus, then read back
                    addr = ($urandom_range(0, 1) == 0) ? sfr_pkg::ADDR_WR_PTR
                                                       : sfr_pkg::ADDR_RD_PTR;
                    send_word(mk_word(sfr_pkg::KIND_WRITE, addr, 8'($urandom), 16'($urandom),
                                      16'($urandom)), 1'b0, '0);
                    send_word(mk_word(sfr_pkg::KIND_READ, addr, 8'($urandom), 16'($urandom),
                                      16'($urandom)), 1'b0, '0);
                end else if (n < 76) begin
                    // soft reset through the mode byte
                    data = 8'($urandom);
                    data[sfr_pkg::MODE_RESET_BIT] = 1'b1;
                    send_word(mk_word(sfr_pkg::KIND_WRITE, sfr_pkg::ADDR_MODE, data,
                                      16'($urandom), 16'($urandom)), 1'b0, '0);
                end else if (n < 86) begin
                    // status, ids, pointers, counts and stray addresses
                    case ($urandom_range(0, 6))
                        0:       addr = sfr_pkg::ADDR_IRQ_STATUS;
                        1:       addr = sfr_pkg::ADDR_WR_PTR;
                        2:       addr = sfr_pkg::ADDR_RD_PTR;
                        3:       addr = sfr_pkg::ADDR_OVF_COUNT;
                        4:       addr = sfr_pkg::ADDR_REV_ID;
                        5:       addr = sfr_pkg::ADDR_PART_ID;
                        default: addr = 8'($urandom);
                    endcase
                    send_word(mk_word(sfr_pkg::KIND_READ, addr, 8'($urandom), 16'($urandom),
                                      16'($urandom)), 1'b0, '0);
                end else begin
                    // noise: any kind, any address, any data
                    w = mk_word(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                                16'($urandom), 16'($urandom));
                    send_word(w, 1'b0, '0);
                end
            end
        end

        drain_replies();

        $display("tb: %0d words sent, %0d replies checked, %0d ring bytes read back",
                 words_sent, replies_checked, ring_bytes_read);
        $display("tb: %0d samples lost to a full ring, %0d soft resets, %0d revision id settings",
                 samples_dropped, device_clears, PHASES - 1);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // hard stop if the block hangs
    initial begin : watchdog
        #5ms;
        $display("tb: failure");
        $finish;
    end

endmodule
